// ===== src/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int DefMaxTasks = 16;
  localparam int IdW         = 8;
  localparam int TimeW       = 16;
  localparam int PriW        = 8;

  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] remaining;
    logic [PriW-1:0]  prio;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } sel_ctrl_t;

endpackage

// ===== src/pps_if.sv =====
// ----------------------------------------------------------------------------
// pps_in_if / pps_out_if
// Valid/ready channels carrying scheduler input and result words.
// ----------------------------------------------------------------------------
interface pps_in_if;
  import pps_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [IdW-1:0]    task_id;
  logic [TimeW-1:0]  arrival_time;
  logic [TimeW-1:0]  burst_length;
  logic [PriW-1:0]   task_priority;

  modport source (output valid, operation, task_id, arrival_time, burst_length,
                  task_priority, input ready);
  modport sink   (input valid, operation, task_id, arrival_time, burst_length,
                  task_priority, output ready);
endinterface

interface pps_out_if;
  import pps_pkg::*;

  logic              valid;
  logic              ready;
  logic              ran_valid;
  logic [IdW-1:0]    ran_task_id;
  logic              task_completed;
  logic [TimeW-1:0]  time_now;
  logic              all_done;

  modport source (output valid, ran_valid, ran_task_id, task_completed, time_now,
                  all_done, input ready);
  modport sink   (input valid, ran_valid, ran_task_id, task_completed, time_now,
                  all_done, output ready);
endinterface

// ===== src/pps_best_sel.sv =====
// ----------------------------------------------------------------------------
// pps_best_sel
// Running selection of the best eligible slot and count of unfinished slots.
// ----------------------------------------------------------------------------
module pps_best_sel #(
  parameter int MAX_TASKS = pps_pkg::DefMaxTasks
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pps_pkg::sel_ctrl_t                  ctrl,
  input  logic [$clog2(MAX_TASKS)-1:0]        entry_idx,
  input  pps_pkg::slot_t                      entry,
  input  logic [pps_pkg::TimeW-1:0]           now,
  output logic                                have,
  output logic [$clog2(MAX_TASKS)-1:0]        best_idx,
  output pps_pkg::slot_t                      best,
  output logic [$clog2(MAX_TASKS+1)-1:0]      nz_count
);
  import pps_pkg::*;

  localparam int CntW = $clog2(MAX_TASKS+1);

  logic eligible;
  logic better;

  assign eligible = (entry.arrival <= now) && (entry.remaining != '0);
  assign better   = !have || (entry.prio < best.prio) ||
                    ((entry.prio == best.prio) && (entry.arrival < best.arrival));

  always_ff @(posedge clk) begin
    if (rst) begin
      have     <= 1'b0;
      nz_count <= '0;
    end else if (ctrl.clear) begin
      have     <= 1'b0;
      nz_count <= '0;
    end else if (ctrl.sample) begin
      if (entry.remaining != '0) begin
        nz_count <= nz_count + CntW'(1);
      end
      if (eligible && better) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sample && !ctrl.clear && eligible && better) begin
      best_idx <= entry_idx;
      best     <= entry;
    end
  end

endmodule

// ===== src/preemptive_priority_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Task table in one synchronous memory; a tick scans it one slot per cycle.
// ----------------------------------------------------------------------------
// Load: no result word; the next word can follow at once.
// Tick: one memory read per slot, then a pick and write-back of the best slot;
//   the result word is registered on that write-back, which waits while an
//   earlier result is still held. The next word is taken after the write-back.
// Reset: slot count and time clear at once; table contents stay undefined.
module preemptive_priority_scheduler_top #(
  parameter int MAX_TASKS = pps_pkg::DefMaxTasks
) (
  input  logic       clk,
  input  logic       rst,
  pps_in_if.sink     req,
  pps_out_if.source  rsp
);
  import pps_pkg::*;

  localparam int IdxW = $clog2(MAX_TASKS);
  localparam int CntW = $clog2(MAX_TASKS+1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t            state;
  logic [CntW-1:0]   slot_count;
  logic [TimeW-1:0]  current_time;
  logic [TimeW-1:0]  time_next;
  logic [CntW-1:0]   scan_cnt;

  slot_t             mem [MAX_TASKS];
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  slot_t             wr_data;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  slot_t             rd_data;
  logic              rd_vld;
  logic [IdxW-1:0]   rd_idx;

  sel_ctrl_t         sel_ctrl;
  logic              have;
  logic [IdxW-1:0]   best_idx;
  slot_t             best;
  logic [CntW-1:0]   nz_count;

  logic              accept;
  logic              advance;
  logic              done;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign advance   = (state == ST_WRITE) && (!rsp.valid || rsp.ready);
  assign done      = have && (best.remaining == TimeW'(1));
  assign time_next = (current_time == TimeMax) ? current_time : current_time + TimeW'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_count[IdxW-1:0];
    wr_data = '{id: req.task_id, arrival: req.arrival_time,
                remaining: req.burst_length, prio: req.task_priority};
    rd_en   = 1'b0;
    rd_addr = scan_cnt[IdxW-1:0];
    sel_ctrl.clear  = 1'b0;
    sel_ctrl.sample = rd_vld;
    case (state)
      ST_IDLE: begin
        if (accept && (req.operation == OP_LOAD) && (slot_count < CntW'(MAX_TASKS))) begin
          wr_en = 1'b1;
        end
        if (accept && (req.operation == OP_TICK)) begin
          sel_ctrl.clear = 1'b1;
          rd_en          = (slot_count != '0);
          rd_addr        = '0;
        end
      end
      ST_SCAN: begin
        rd_en = (scan_cnt != slot_count);
      end
      ST_WRITE: begin
        if (advance && have) begin
          wr_en   = 1'b1;
          wr_addr = best_idx;
          wr_data = best;
          wr_data.remaining = best.remaining - TimeW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_idx  <= rd_addr;
    end
  end

  pps_best_sel #(
    .MAX_TASKS (MAX_TASKS)
  ) u_best_sel (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sel_ctrl),
    .entry_idx (rd_idx),
    .entry     (rd_data),
    .now       (current_time),
    .have      (have),
    .best_idx  (best_idx),
    .best      (best),
    .nz_count  (nz_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot_count   <= '0;
      current_time <= '0;
      scan_cnt     <= '0;
      rd_vld       <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (advance) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (req.operation == OP_LOAD)) begin
            if (slot_count < CntW'(MAX_TASKS)) begin
              slot_count <= slot_count + CntW'(1);
            end
          end else if (accept) begin
            scan_cnt <= CntW'(1);
            state    <= (slot_count == '0) ? ST_WRITE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_cnt == slot_count) begin
            state <= ST_WRITE;
          end else begin
            scan_cnt <= scan_cnt + CntW'(1);
          end
        end
        ST_WRITE: begin
          if (advance) begin
            current_time <= time_next;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.ran_valid      <= have;
      rsp.ran_task_id    <= have ? best.id : '0;
      rsp.task_completed <= done;
      rsp.time_now       <= time_next;
      rsp.all_done       <= ((nz_count - (done ? CntW'(1) : CntW'(0))) == '0);
    end
  end

endmodule

// ===== test/tb_preemptive_priority_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler_top
// Self-checking bench for the priority scheduler. A short table of directed
// words opens the run: empty table, zero burst, future arrival, tie breaks,
// extreme field values. Random loads and ticks with bursty idling on both
// channels follow, and a closing stretch runs with no idling at all.
// Every result word is checked against a local scheduling model, or against the typed result of an opening row.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int Slots      = DefMaxTasks;
  localparam int StallLimit = 2000;

  typedef struct packed {
    logic             served;
    logic [IdW-1:0]   id;
    logic             finished;
    logic [TimeW-1:0] now;
    logic             all_done;
  } tick_report_t;

  typedef struct packed {
    op_t              op;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] burst;
    logic [PriW-1:0]  prio;
    logic             typed;
    tick_report_t     want;
  } sched_word_t;

  // typed rows carry the result that follows directly from the rules
  localparam sched_word_t Opening [20] = '{
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 16'd1, 1'b1}},
    '{OP_LOAD, 8'hFF, 16'h0000, 16'h0000, 8'h00, 1'b0, '0},
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 16'd2, 1'b1}},
    '{OP_LOAD, 8'h00, 16'h0000, 16'h0001, 8'hFF, 1'b0, '0},
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, '{1'b1, 8'h00, 1'b1, 16'd3, 1'b1}},
    '{OP_LOAD, 8'h11, 16'h0005, 16'h0003, 8'h07, 1'b0, '0},
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 16'd4, 1'b0}},
    '{OP_LOAD, 8'h22, 16'h0004, 16'h0002, 8'h07, 1'b0, '0},
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, '0},
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, '0},
    '{OP_LOAD, 8'h33, 16'h0000, 16'h0002, 8'h07, 1'b0, '0},
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, '0},
    '{OP_LOAD, 8'h44, 16'h0000, 16'h0001, 8'h07, 1'b0, '0},
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, '0},
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, '0},
    '{OP_LOAD, 8'h55, 16'h0000, 16'h7FFF, 8'hFE, 1'b0, '0},
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, '0},
    '{OP_LOAD, 8'hAA, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, '0},
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, '0},
    '{OP_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, '0}
  };

  logic clk;
  logic rst;

  pps_in_if  req_ch ();
  pps_out_if rsp_ch ();

  preemptive_priority_scheduler_top #(
    .MAX_TASKS(Slots)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // scheduling model state
  logic [IdW-1:0]   tag_of     [Slots];
  logic [TimeW-1:0] arrival_of [Slots];
  logic [TimeW-1:0] left_of    [Slots];
  logic [PriW-1:0]  prio_of    [Slots];
  int               slots_used;
  logic [TimeW-1:0] clock_now;

  tick_report_t reports_due [$];

  int  items_taken;
  int  mismatch_count;
  int  quiet_cycles = 0;
  int  loads_stored;
  int  loads_dropped;
  int  ticks_served;
  int  ticks_idle;
  int  tasks_finished;
  bit  bubbles_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void store_task(input sched_word_t w);
    if (slots_used < Slots) begin
      tag_of[slots_used]     = w.id;
      arrival_of[slots_used] = w.arrival;
      left_of[slots_used]    = w.burst;
      prio_of[slots_used]    = w.prio;
      slots_used++;
      loads_stored++;
    end else begin
      loads_dropped++;
    end
  endfunction

  function automatic tick_report_t run_tick();
    tick_report_t r;
    int best;
    best = -1;
    for (int k = 0; k < slots_used; k++) begin
      if (arrival_of[k] <= clock_now && left_of[k] != '0) begin
        if (best < 0 || prio_of[k] < prio_of[best] ||
            (prio_of[k] == prio_of[best] && arrival_of[k] < arrival_of[best]))
          best = k;
      end
    end
    if (clock_now != TimeMax) clock_now++;
    r = '0;
    r.now = clock_now;
    if (best >= 0) begin
      left_of[best]--;
      r.served   = 1'b1;
      r.id       = tag_of[best];
      r.finished = (left_of[best] == '0);
      ticks_served++;
      if (r.finished) tasks_finished++;
    end else begin
      ticks_idle++;
    end
    r.all_done = 1'b1;
    for (int k = 0; k < slots_used; k++) begin
      if (left_of[k] != '0) r.all_done = 1'b0;
    end
    return r;
  endfunction

  function automatic sched_word_t random_word(input op_t op);
    sched_word_t w;
    w = '0;
    w.op      = op;
    w.id      = 8'($urandom);
    w.arrival = 16'($urandom);
    w.burst   = 16'($urandom);
    w.prio    = 8'($urandom);
    if (op == OP_LOAD && slots_used < Slots) begin
      if ($urandom_range(0, 1) == 0) w.prio = 8'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0: w.arrival = (clock_now > TimeMax - 16'd40) ? clock_now :
                       clock_now + 16'($urandom_range(1, 40));
        1: w.arrival = 16'($urandom_range(0, clock_now));
        default: ;
      endcase
      // long bursts stay in the background so they do not starve the rest
      case ($urandom_range(0, 7))
        0: w.burst = '0;
        1, 2: w.prio[PriW-1] = 1'b1;
        default: w.burst = 16'($urandom_range(1, 40));
      endcase
    end
    return w;
  endfunction

  task automatic send_word(input sched_word_t w);
    tick_report_t r;
    if (bubbles_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= w.op;
    req_ch.task_id       <= w.id;
    req_ch.arrival_time  <= w.arrival;
    req_ch.burst_length  <= w.burst;
    req_ch.task_priority <= w.prio;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_taken++;
    if (w.op == OP_LOAD) begin
      store_task(w);
    end else begin
      r = run_tick();
      reports_due.push_back(w.typed ? w.want : r);
    end
  endtask

  task automatic random_stretch(input int n, input int fill_to, input bit with_bubbles);
    int goal;
    goal = items_taken + n;
    bubbles_on = with_bubbles;
    while (items_taken < goal) begin
      if (with_bubbles && items_taken % 64 == 0) bubbles_on = ($urandom_range(0, 3) != 0);
      if (slots_used < fill_to && $urandom_range(0, 29) == 0)
        send_word(random_word(OP_LOAD));
      else if (slots_used == Slots && $urandom_range(0, 7) == 0)
        send_word(random_word(OP_LOAD));
      else
        send_word(random_word(OP_TICK));
    end
  endtask

  // result side: ready drops in bursts while idling is on
  initial begin
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (bubbles_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tick_report_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (reports_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result word with nothing pending", $realtime);
      end else begin
        want = reports_due.pop_front();
        if (rsp_ch.ran_valid !== want.served || rsp_ch.ran_task_id !== want.id ||
            rsp_ch.task_completed !== want.finished || rsp_ch.time_now !== want.now ||
            rsp_ch.all_done !== want.all_done) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("%0t: expected ran=%0d id=%02h done=%0d time=%0d all=%0d, ",
                   $realtime, want.served, want.id, want.finished, want.now,
                   want.all_done);
            $display("got ran=%0d id=%02h done=%0d time=%0d all=%0d",
                     rsp_ch.ran_valid, rsp_ch.ran_task_id, rsp_ch.task_completed,
                     rsp_ch.time_now, rsp_ch.all_done);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == StallLimit) begin
      $display("%0t: no word moved for %0d cycles", $realtime, StallLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= OP_LOAD;
    req_ch.task_id       <= '0;
    req_ch.arrival_time  <= '0;
    req_ch.burst_length  <= '0;
    req_ch.task_priority <= '0;
    slots_used     = 0;
    clock_now      = '0;
    items_taken    = 0;
    mismatch_count = 0;
    loads_stored   = 0;
    loads_dropped  = 0;
    ticks_served   = 0;
    ticks_idle     = 0;
    tasks_finished = 0;
    bubbles_on     = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (Opening[i]) send_word(Opening[i]);

    random_stretch(1000, 12, 1'b1);
    random_stretch(350, Slots, 1'b1);
    random_stretch(100, Slots, 1'b0);
    req_ch.valid <= 1'b0;

    while (reports_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d ticks: %0d served, %0d idle, %0d tasks finished; final time %0d.",
             ticks_served + ticks_idle, ticks_served, ticks_idle, tasks_finished, clock_now);
    $display("Loaded %0d tasks, %0d more dropped on a full table, %0d mismatches.",
             loads_stored, loads_dropped, mismatch_count);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
